>>> rtl/lpe_pkg.sv
// Shared widths, register indexes and controller/datapath types of the Legendre evaluator.
package lpe_pkg;

	localparam int DEGREE_W = 6;
	localparam int INDEX_W = 12;
	localparam int COUNT_W = 13;
	localparam int RECIP_BITS = 24;

	localparam int DEF_MAX_DEGREE = 63;
	localparam int DEF_MAX_POINTS = 4096;
	localparam int DEF_FRAC_BITS = 16;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEGREE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b1;

	// Source of the value that goes into the output register.
	typedef enum logic [1:0] {
		SEL_ONE,
		SEL_X,
		SEL_REC
	} lpe_sel_t;

	typedef struct packed {
		logic                load;
		logic                div_step;
		logic                mul_x;
		logic                mul_s;
		logic                mul_r;
		logic                emit;
		logic                shift;
		lpe_sel_t            sel;
		logic [DEGREE_W-1:0] degree;
		logic                last;
	} lpe_cmd_t;

	typedef struct packed {
		logic out_free;
	} lpe_sts_t;

endpackage

>>> rtl/lpe_if.sv
// Valid/ready channel interfaces for grid point requests and polynomial results.
interface lpe_pt_if
	import lpe_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] point_index;

	modport source (output valid, output point_index, input ready);
	modport sink (input valid, input point_index, output ready);
endinterface

interface lpe_res_if
	import lpe_pkg::*;
#(
	parameter int VALUE_W = DEF_FRAC_BITS + 2
) ();
	logic                      valid;
	logic                      ready;
	logic [DEGREE_W-1:0]       degree;
	logic signed [VALUE_W-1:0] value;
	logic                      last;

	modport source (output valid, output degree, output value, output last, input ready);
	modport sink (input valid, input degree, input value, input last, output ready);
endinterface

>>> rtl/lpe_datapath.sv
// Datapath: serial abscissa divider, recurrence multiply chain and output register.
module lpe_datapath
	import lpe_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpe_cmd_t                      cmd,
	output lpe_sts_t                      sts,
	input  logic [INDEX_W-1:0]            point_index,
	input  logic [COUNT_W-1:0]            span,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [DEGREE_W-1:0]           out_degree,
	output logic signed [FRAC_BITS+1:0]   out_value,
	output logic                          out_last
);

	localparam int VW = FRAC_BITS + 2;
	localparam int PW = 2 * VW;
	localparam int SW = VW + 7;
	localparam int TW = VW + 8;
	localparam int MW = SW + RECIP_BITS + 1;
	localparam int RW = MW - RECIP_BITS;
	localparam int NUM_W = INDEX_W + FRAC_BITS + 3;
	localparam int DW = COUNT_W + 1;
	localparam int TAB_N = 2 ** DEGREE_W;

	localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
	localparam logic signed [PW-1:0] PROD_HALF = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [MW-1:0] REC_HALF = MW'(1) << (RECIP_BITS - 1);
	localparam logic signed [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;

	logic [RECIP_BITS-1:0] rcp_tab [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_rcp
		localparam longint unsigned RV =
			((64'd1 << (RECIP_BITS + 1)) / ((g == 0) ? 1 : g) + 1) >> 1;
		assign rcp_tab[g] = RECIP_BITS'(RV);
	end

	logic [NUM_W-1:0]        dnum_q;
	logic [DW-1:0]           drem_q;
	logic [DW-1:0]           dden_q;
	logic signed [VW-1:0]    p1_q;
	logic signed [VW-1:0]    p2_q;
	logic signed [PW-1:0]    prod_s1;
	logic signed [SW-1:0]    t1_s2;
	logic signed [SW-1:0]    t2_s2;
	logic signed [MW-1:0]    m_s3;
	logic                    out_valid_q;
	logic [DEGREE_W-1:0]     out_degree_q;
	logic signed [VW-1:0]    out_value_q;
	logic                    out_last_q;

	logic [COUNT_W-1:0]      idx_c;
	logic [DW:0]             trial;
	logic [DW:0]             diff;
	logic                    ge;
	logic signed [VW-1:0]    xval;
	logic signed [PW-1:0]    prod_r;
	logic signed [VW-1:0]    xp;
	logic signed [7:0]       c1;
	logic signed [7:0]       c2;
	logic signed [VW+7:0]    t1_full;
	logic signed [VW+7:0]    t2_full;
	logic signed [SW-1:0]    s_val;
	logic signed [MW-1:0]    m_r;
	logic signed [RW-1:0]    rec_r;
	logic signed [VW-1:0]    rec_sat;
	logic signed [VW-1:0]    cur;

	always_comb begin
		idx_c = COUNT_W'(point_index);
		if (idx_c > span) begin
			idx_c = span;
		end
	end

	assign trial = {drem_q, dnum_q[NUM_W-1]};
	assign diff = trial - {1'b0, dden_q};
	assign ge = ~diff[DW];

	// The quotient is at most 2^(FRAC_BITS+1), so its low VW bits hold it.
	assign xval = $signed(dnum_q[VW-1:0]) - ONE_V;

	assign prod_r = prod_s1 + PROD_HALF;
	assign xp = VW'(prod_r >>> FRAC_BITS);
	assign c1 = $signed({1'b0, cmd.degree, 1'b0}) - 8'sd1;
	assign c2 = $signed({2'b00, cmd.degree}) - 8'sd1;
	assign t1_full = TW'(c1) * TW'(xp);
	assign t2_full = TW'(c2) * TW'(p2_q);
	assign s_val = t1_s2 - t2_s2;

	assign m_r = m_s3 + REC_HALF;
	assign rec_r = RW'(m_r >>> RECIP_BITS);

	always_comb begin
		if (rec_r > ONE_R) begin
			rec_sat = ONE_V;
		end else if (rec_r < -ONE_R) begin
			rec_sat = -ONE_V;
		end else begin
			rec_sat = VW'(rec_r);
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_ONE: cur = ONE_V;
			SEL_X:   cur = xval;
			SEL_REC: cur = rec_sat;
			default: cur = ONE_V;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dnum_q <= (NUM_W'(idx_c) << (FRAC_BITS + 2)) + NUM_W'(span);
			drem_q <= '0;
			dden_q <= {span, 1'b0};
			p1_q <= ONE_V;
			p2_q <= '0;
		end else begin
			if (cmd.div_step) begin
				drem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
				dnum_q <= {dnum_q[NUM_W-2:0], ge};
			end
			if (cmd.emit && cmd.shift) begin
				p2_q <= p1_q;
				p1_q <= cur;
			end
		end
		if (cmd.mul_x) begin
			prod_s1 <= PW'(xval) * PW'(p1_q);
		end
		if (cmd.mul_s) begin
			t1_s2 <= SW'(t1_full);
			t2_s2 <= SW'(t2_full);
		end
		if (cmd.mul_r) begin
			m_s3 <= MW'(s_val) * MW'($signed({1'b0, rcp_tab[cmd.degree]}));
		end
		if (cmd.emit) begin
			out_degree_q <= cmd.degree;
			out_value_q <= cur;
			out_last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;
	assign out_degree = out_degree_q;
	assign out_value = out_value_q;
	assign out_last = out_last_q;

endmodule

>>> rtl/lpe_ctrl.sv
// Controller: sequences the divider, the per-degree multiply chain and result emission.
module lpe_ctrl
	import lpe_pkg::*;
#(
	parameter int DIV_STEPS = INDEX_W + DEF_FRAC_BITS + 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DEGREE_W-1:0] n_eff,
	input  lpe_sts_t            sts,
	output lpe_cmd_t            cmd
);

	localparam int CW = $clog2(DIV_STEPS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_EMIT,
		S_MULX,
		S_MULS,
		S_MULR
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic [DEGREE_W-1:0] j_q;
	logic [DEGREE_W-1:0] n_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.div_step = (state_q == S_DIV);
		cmd.mul_x = (state_q == S_MULX);
		cmd.mul_s = (state_q == S_MULS);
		cmd.mul_r = (state_q == S_MULR);
		cmd.emit = (state_q == S_EMIT) && sts.out_free;
		cmd.shift = (j_q != '0);
		cmd.degree = j_q;
		cmd.last = (j_q == n_q);
		if (j_q == DEGREE_W'(0)) begin
			cmd.sel = SEL_ONE;
		end else if (j_q == DEGREE_W'(1)) begin
			cmd.sel = SEL_X;
		end else begin
			cmd.sel = SEL_REC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			j_q <= '0;
			n_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						n_q <= n_eff;
						j_q <= '0;
						cnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DIV_STEPS - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (sts.out_free) begin
						if (j_q == n_q) begin
							state_q <= S_IDLE;
						end else begin
							j_q <= j_q + DEGREE_W'(1);
							state_q <= (j_q == '0) ? S_EMIT : S_MULX;
						end
					end
				end
				S_MULX: state_q <= S_MULS;
				S_MULS: state_q <= S_MULR;
				S_MULR: state_q <= S_EMIT;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result written while the output register is occupied");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == S_IDLE))
		else $error("sequence did not end after the last degree");

	a_load_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DIV && j_q == '0 && cnt_q == '0))
		else $error("accepted point did not start the division");

	a_degree_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (j_q <= n_q))
		else $error("degree counter ran past the highest degree");

endmodule

>>> rtl/legendre_polynomial_evaluator_core.sv
// Top level of the Legendre polynomial evaluator: configuration registers and unit hookup.
//
// For each accepted grid point index i this block computes x = -1 + 2i/(N-1) on a grid of
// N points and returns P0..Pn at x, one result transaction per degree in rising order, with
// last set on degree n. Values are signed Q1.FRAC_BITS, rounded to nearest and saturated to
// [-1, +1]; higher degrees use Pj = ((2j-1) x Pj-1 - (j-1) Pj-2) / j with a constant table
// of rounded reciprocals 1/j. Register 0 (max_degree, reset 2) sets n and is limited to
// MAX_DEGREE; register 1 (point_count, reset 2) sets N, taken as 2 when below 2 and limited
// to MAX_POINTS. An index at or past the last grid point yields x = +1. Configuration may be
// written only while no point is in progress. The abscissa comes from a restoring divider
// that produces one quotient bit per cycle, and each higher degree then runs through a chain
// of the x*Pj-1 multiply, the coefficient multiplies, the reciprocal multiply and the rounding.
// The next point is accepted once the last result of the current one sits in the output
// register, even if the sink has not taken it yet; stalls on the result side stretch this.
module legendre_polynomial_evaluator_core
	import lpe_pkg::*;
#(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [COUNT_W-1:0]   cfg_wdata,
	lpe_pt_if.sink               pt_in,
	lpe_res_if.source            res_out
);

	localparam int NUM_W = INDEX_W + FRAC_BITS + 3;

	// Software-visible registers, reset to degree 2 on a two-point grid.
	logic [DEGREE_W-1:0] max_degree_q;
	logic [COUNT_W-1:0]  point_count_q;

	logic [DEGREE_W-1:0] n_eff;
	logic [COUNT_W-1:0]  n_pts;
	logic [COUNT_W-1:0]  span;
	lpe_cmd_t            cmd;
	lpe_sts_t            sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_degree_q <= DEGREE_W'(2);
			point_count_q <= COUNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_DEGREE:  max_degree_q <= cfg_wdata[DEGREE_W-1:0];
				REG_POINT_COUNT: point_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective degree and grid span after the limits are applied.
	always_comb begin
		if (32'(max_degree_q) > MAX_DEGREE) begin
			n_eff = DEGREE_W'(MAX_DEGREE);
		end else begin
			n_eff = max_degree_q;
		end
		if (point_count_q < COUNT_W'(2)) begin
			n_pts = COUNT_W'(2);
		end else if (32'(point_count_q) > MAX_POINTS) begin
			n_pts = COUNT_W'(MAX_POINTS);
		end else begin
			n_pts = point_count_q;
		end
		span = n_pts - COUNT_W'(1);
	end

	lpe_ctrl #(
		.DIV_STEPS(NUM_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pt_in.valid),
		.in_ready (pt_in.ready),
		.n_eff    (n_eff),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpe_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.point_index (pt_in.point_index),
		.span        (span),
		.out_ready   (res_out.ready),
		.out_valid   (res_out.valid),
		.out_degree  (res_out.degree),
		.out_value   (res_out.value),
		.out_last    (res_out.last)
	);

endmodule

>>> tb/legendre_polynomial_evaluator_core_test.sv
// Self-checking testbench for the Legendre polynomial evaluator core.
`timescale 1ns / 1ps

module legendre_polynomial_evaluator_core_test;
	import lpe_pkg::*;

	localparam int VALUE_W = DEF_FRAC_BITS + 2;
	localparam longint UNIT = longint'(1) << DEF_FRAC_BITS;
	// Share of cycles in which either side idles, in percent.
	localparam int IDLE_PCT = 33;
	// Length of the long result-side hold-off that fills the block and stalls its input.
	localparam int HOLD_OFF_CYCLES = 800;
	// Cycles without any accepted transaction before the run is declared hung. The worst
	// correct gap is the hold-off plus a full degree-63 point.
	localparam int QUIET_LIMIT = 20000;
	// Quiet time after the last result before a register write, and at the very end.
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES = 300;
	localparam int TOTAL_POINTS = 200;

	typedef struct packed {
		logic [DEGREE_W-1:0]       degree;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} legendre_term_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [COUNT_W-1:0]   cfg_wdata;

	lpe_pt_if  pt_chan ();
	lpe_res_if #(.VALUE_W(VALUE_W)) res_chan ();

	legendre_polynomial_evaluator_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.pt_in    (pt_chan),
		.res_out  (res_chan)
	);

	// Shadow copy of the configuration registers as the block sees them.
	logic [DEGREE_W-1:0] cur_max_degree = 6'd2;
	logic [COUNT_W-1:0]  cur_point_count = 13'd2;

	// Grid indexes waiting to be offered, and the polynomial values still owed by the block.
	logic [INDEX_W-1:0] point_queue[$];
	legendre_term_t     legendre_expected[$];

	int  points_in_flight = 0;
	int  quiet_cycles = 0;
	int  mismatch_count = 0;
	bit  point_taken = 1'b0;
	// While set, neither side idles.
	bit  calm_stretch = 1'b0;
	// The stimulus bumps the request count; the receiver answers each bump with one hold-off.
	int  hold_off_req = 0;
	int  hold_off_seen = 0;
	int  hold_off_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Works out P0..Pn at the abscissa of one grid index under the current settings, exactly
	// as the hardware rounds: x from a half-up rounded division, each product rounded at
	// FRAC_BITS toward +infinity on ties, the reciprocal multiply rounded the same way at
	// RECIP_BITS, and every value clamped to [-1, +1] before it is used again.
	function automatic void expect_legendre_row(input logic [INDEX_W-1:0] idx);
		longint         grid_size;
		longint         span;
		longint         pos;
		longint         x;
		longint         p1;
		longint         p2;
		longint         cur;
		longint         xp;
		longint         acc;
		longint         recip;
		int             top;
		int             j;
		legendre_term_t term;

		grid_size = longint'(cur_point_count);
		if (grid_size < 2)
			grid_size = 2;
		if (grid_size > DEF_MAX_POINTS)
			grid_size = DEF_MAX_POINTS;
		span = grid_size - 1;
		top = int'(cur_max_degree);
		if (top > DEF_MAX_DEGREE)
			top = DEF_MAX_DEGREE;

		// An index past the grid lands on the last point, x = +1.
		pos = longint'(idx);
		if (pos > span)
			pos = span;
		x = ((pos << (DEF_FRAC_BITS + 2)) + span) / (2 * span) - UNIT;

		p2 = 0;
		p1 = UNIT;
		for (j = 0; j <= top; j++) begin
			if (j == 0) begin
				cur = UNIT;
			end else if (j == 1) begin
				cur = x;
			end else begin
				xp = (x * p1 + (longint'(1) << (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS;
				acc = longint'(2 * j - 1) * xp - longint'(j - 1) * p2;
				recip = (((longint'(1) << (RECIP_BITS + 1)) / j) + 1) >>> 1;
				cur = (acc * recip + (longint'(1) << (RECIP_BITS - 1))) >>> RECIP_BITS;
				if (cur > UNIT)
					cur = UNIT;
				if (cur < -UNIT)
					cur = -UNIT;
			end
			if (j >= 1) begin
				p2 = p1;
				p1 = cur;
			end
			term.degree = DEGREE_W'(j);
			term.value = cur[VALUE_W-1:0];
			term.last = (j == top);
			legendre_expected.push_back(term);
		end
	endfunction

	// Returns the last valid index of the grid that the current point_count selects.
	function automatic int grid_last_index();
		int grid_size;

		grid_size = int'(cur_point_count);
		if (grid_size < 2)
			grid_size = 2;
		if (grid_size > DEF_MAX_POINTS)
			grid_size = DEF_MAX_POINTS;
		return grid_size - 1;
	endfunction

	// Mostly indexes on the grid, with the end points and out-of-grid indexes mixed in.
	function automatic logic [INDEX_W-1:0] pick_point_index();
		int roll;

		roll = $urandom_range(99);
		if (roll < 70)
			return INDEX_W'($urandom_range(grid_last_index()));
		else if (roll < 80)
			return '0;
		else if (roll < 88)
			return INDEX_W'(grid_last_index());
		else
			return INDEX_W'($urandom);
	endfunction

	// Register writes happen on the falling edge and take effect at the next rising edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		if (idx == REG_MAX_DEGREE)
			cur_max_degree = data[DEGREE_W-1:0];
		else
			cur_point_count = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_point(input logic [INDEX_W-1:0] idx);
		point_queue.push_back(idx);
		points_in_flight++;
	endtask

	// Waits until every queued point has been taken and every result has come back. The
	// counters only change on rising edges, so checking them on falling edges is race free.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (points_in_flight != 0 || legendre_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Point sender. A transaction that is on offer stays put until it is accepted; otherwise
	// the next pending index goes out, unless this cycle is picked as an idle one. The line
	// stays idle while reset is asserted.
	always @(negedge clk) begin
		if (!arst_n) begin
			pt_chan.valid <= 1'b0;
			pt_chan.point_index <= '0;
		end else if (!pt_chan.valid || point_taken) begin
			point_taken = 1'b0;
			if (point_queue.size() != 0 && (calm_stretch || $urandom_range(99) >= IDLE_PCT)) begin
				pt_chan.valid <= 1'b1;
				pt_chan.point_index <= point_queue.pop_front();
			end else begin
				pt_chan.valid <= 1'b0;
				pt_chan.point_index <= INDEX_W'($urandom);
			end
		end
	end

	// Result receiver. Stalls at random, and on request holds ready low for a long stretch
	// so that results back up in the block and the point input stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_chan.ready <= 1'b0;
		end else if (hold_off_left != 0) begin
			hold_off_left--;
			res_chan.ready <= 1'b0;
		end else if (hold_off_seen != hold_off_req) begin
			hold_off_seen = hold_off_req;
			hold_off_left = HOLD_OFF_CYCLES - 1;
			res_chan.ready <= 1'b0;
		end else begin
			res_chan.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Monitor. On each rising edge an accepted point transaction gets its expected row of
	// values, and an accepted result transaction is checked against the oldest expectation.
	always @(posedge clk) begin
		legendre_term_t want;

		if (arst_n) begin
			quiet_cycles++;
			if (pt_chan.valid && pt_chan.ready) begin
				quiet_cycles = 0;
				point_taken = 1'b1;
				points_in_flight--;
				expect_legendre_row(pt_chan.point_index);
			end
			if (res_chan.valid && res_chan.ready) begin
				quiet_cycles = 0;
				if (legendre_expected.size() == 0) begin
					$error("result with no expectation: degree %0d value %0d last %0b",
						res_chan.degree, $signed(res_chan.value), res_chan.last);
					mismatch_count++;
				end else begin
					want = legendre_expected.pop_front();
					if (res_chan.degree !== want.degree) begin
						$error("degree: expected %0d, got %0d", want.degree, res_chan.degree);
						mismatch_count++;
					end
					if (res_chan.value !== want.value) begin
						$error("value: expected %0d, got %0d (degree %0d)",
							$signed(want.value), $signed(res_chan.value), want.degree);
						mismatch_count++;
					end
					if (res_chan.last !== want.last) begin
						$error("last: expected %0b, got %0b (degree %0d)",
							want.last, res_chan.last, want.degree);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		int phase;
		int batch;
		int sent;
		int roll;

		// Reset and the register port are known from time zero; reset is held asserted at the
		// start, and the channel processes keep their lines idle meanwhile.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MAX_DEGREE;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		fork
			begin
				// Reset settings: a two-point grid, degrees 0 to 2. Index 4095 is past the grid.
				queue_point(12'd0);
				queue_point(12'd1);
				queue_point(12'd4095);
				wait_idle();

				// Largest degree on the largest grid: both end points, the points around the
				// middle and single index bits.
				write_reg(REG_MAX_DEGREE, 13'd63);
				write_reg(REG_POINT_COUNT, 13'd4096);
				queue_point(12'd0);
				queue_point(12'd4095);
				queue_point(12'd2048);
				queue_point(12'd2047);
				queue_point(12'd1365);
				queue_point(12'd1);
				wait_idle();

				// A grid size above the maximum is taken as the maximum.
				write_reg(REG_POINT_COUNT, 13'h1FFF);
				queue_point(12'd4095);
				queue_point(12'd2730);
				wait_idle();

				// Upper data bits of a degree write are dropped; a grid of zero points is
				// taken as two.
				write_reg(REG_MAX_DEGREE, 13'h1FC1);
				write_reg(REG_POINT_COUNT, 13'd0);
				queue_point(12'd0);
				queue_point(12'd1);
				queue_point(12'd2);
				wait_idle();

				// Degree zero only, on a grid of one point (taken as two).
				write_reg(REG_MAX_DEGREE, 13'd0);
				write_reg(REG_POINT_COUNT, 13'd1);
				queue_point(12'd0);
				queue_point(12'd5);
				wait_idle();

				// Three points, so the middle one sits exactly at x = 0.
				write_reg(REG_POINT_COUNT, 13'd3);
				queue_point(12'd0);
				queue_point(12'd1);
				queue_point(12'd2);
				queue_point(12'd3);
				wait_idle();

				// One point past the maximum grid size.
				write_reg(REG_MAX_DEGREE, 13'd5);
				write_reg(REG_POINT_COUNT, 13'd4097);
				queue_point(12'd4095);
				queue_point(12'd4094);
				wait_idle();

				// Random phases, each with its own settings. Small degrees keep the run short;
				// a few phases use the full degree range.
				sent = 22;
				phase = 0;
				while (sent < TOTAL_POINTS) begin
					roll = $urandom_range(99);
					if (roll < 15)
						write_reg(REG_MAX_DEGREE,
							COUNT_W'(($urandom & 32'h1FC0) | 32'd63));
					else if (roll < 25)
						write_reg(REG_MAX_DEGREE, 13'd0);
					else
						write_reg(REG_MAX_DEGREE,
							COUNT_W'(($urandom & 32'h1FC0) | $urandom_range(1, 12)));

					roll = $urandom_range(99);
					if (roll < 15)
						write_reg(REG_POINT_COUNT, 13'd4096);
					else if (roll < 22)
						write_reg(REG_POINT_COUNT, COUNT_W'($urandom_range(1)));
					else if (roll < 30)
						write_reg(REG_POINT_COUNT, COUNT_W'($urandom_range(4097, 8191)));
					else if (roll < 60)
						write_reg(REG_POINT_COUNT, COUNT_W'($urandom_range(2, 40)));
					else
						write_reg(REG_POINT_COUNT, COUNT_W'($urandom_range(2, 4096)));

					// One phase runs with no idling at all on either side.
					calm_stretch = (phase == 3);
					// One phase starts with the long result-side hold-off.
					if (phase == 1)
						hold_off_req++;

					batch = $urandom_range(8, 25);
					repeat (batch) queue_point(pick_point_index());
					sent += batch;
					wait_idle();
					phase++;
				end
				calm_stretch = 1'b0;
				repeat (DRAIN_CYCLES) @(negedge clk);
			end
			while (quiet_cycles < QUIET_LIMIT)
				@(negedge clk);
		join_any

		if (quiet_cycles < QUIET_LIMIT && legendre_expected.size() == 0 && mismatch_count == 0)
			$display("legendre_polynomial_evaluator_core verification clean");
		else
			$display("legendre_polynomial_evaluator_core verification failed");
		$finish;
	end

endmodule
